### design/assert_macros.svh
// Assertion helpers shared by the RTL; the checks compile away under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on aclk, masked during reset.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, sampled on aclk, masked during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

### design/erq_pkg.sv
`default_nettype none
package erq_pkg;

    // default list depth
    localparam int QUEUE_DEPTH_DEF = 16;

    // port widths
    localparam int S_DATA_W = 88;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 96;
    localparam int M_USER_W = 3;
    localparam int OCC_W    = 5;

    // one list entry as held in the slot memory
    typedef struct packed {
        logic [31:0] deadline;
        logic [7:0]  ident;
        logic        kind;
        logic [15:0] exec;
        logic [31:0] stamp;
        logic        released;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // sequencer states
    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SCAN_RD  = 7'b0000010,
        ST_SCAN_CHK = 7'b0000100,
        ST_PLACE    = 7'b0001000,
        ST_HEAD_RD  = 7'b0010000,
        ST_HEAD_CHK = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

endpackage
`default_nettype wire

### design/erq_ram.sv
`default_nettype none
// Simple dual-port RAM: one write port, one read port, registered read data.
module erq_ram #(
    parameter int WIDTH = erq_pkg::ENTRY_W,
    parameter int DEPTH = erq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### design/edf_ready_queue_unit.sv
// Steps: an accepted word goes from idle through a read and a check step for each entry
// compared from the tail (n - p moved back for n held and new slot p, one more when p > 0),
// then place, head read, head check and done; without a placed insert it goes straight to
// head read. Done waits while the output register is stalled. The next word is taken once the
// sequencer is back in idle, set by the single read and write port of the slot memory.
// Reset (aresetn low, synchronous) empties the list and the output register at once.
`default_nettype none
module edf_ready_queue_unit #(
    parameter int QUEUE_DEPTH = erq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input words
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [7:0] task_ident, [23:8] exec_ticks, [55:24] deadline_tick, [87:56] now_tick
    input  wire logic [erq_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] insert_valid, [1] task_kind
    input  wire logic [erq_pkg::S_USER_W-1:0]  s_tuser,
    // result words
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [7:0] released_ident, [23:8] released_exec, [55:24] released_deadline,
    // [87:56] release_stamp, [92:88] occupancy, [95:93] zero
    output logic      [erq_pkg::M_DATA_W-1:0]  m_tdata,
    // [0] release_valid, [1] released_kind, [2] insert_dropped
    output logic      [erq_pkg::M_USER_W-1:0]  m_tuser
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [erq_pkg::OCC_W-1:0] OCC_FULL = erq_pkg::OCC_W'(QUEUE_DEPTH);

    erq_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   pos_reg, pos_next;
    erq_pkg::entry_t task_reg, task_next;
    logic [31:0]     now_reg, now_next;
    logic            drop_reg, drop_next;
    logic            rel_reg, rel_next;
    erq_pkg::entry_t head_reg, head_next;

    logic                         m_valid_reg, m_valid_next;
    logic [erq_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;
    logic [erq_pkg::M_USER_W-1:0] m_user_reg, m_user_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    erq_pkg::entry_t ram_wdata;
    logic [AW-1:0]   ram_raddr;
    erq_pkg::entry_t ram_rdata;
    erq_pkg::entry_t head_upd;

    logic list_full;
    logic out_free;

    erq_ram #(
        .WIDTH (erq_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign list_full = (cnt_reg == CW'(QUEUE_DEPTH));
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == erq_pkg::ST_IDLE);

    // head entry stamped and marked released
    always_comb begin
        head_upd          = ram_rdata;
        head_upd.stamp    = now_reg;
        head_upd.released = 1'b1;
    end

    // insertion sequencer: move larger deadlines back one slot from the tail, then place
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        task_next  = task_reg;
        now_next   = now_reg;
        drop_next  = drop_reg;
        rel_next   = rel_reg;
        head_next  = head_reg;
        ram_we     = 1'b0;
        ram_waddr  = pos_reg;
        ram_wdata  = task_reg;
        ram_raddr  = pos_reg - AW'(1);

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            erq_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    task_next.ident    = s_tdata[7:0];
                    task_next.exec     = s_tdata[23:8];
                    task_next.deadline = s_tdata[55:24];
                    task_next.kind     = s_tuser[1];
                    task_next.stamp    = '0;
                    task_next.released = 1'b0;
                    now_next           = s_tdata[87:56];
                    drop_next          = s_tuser[0] && list_full;
                    rel_next           = 1'b0;
                    head_next          = '0;
                    pos_next           = cnt_reg[AW-1:0];
                    if (s_tuser[0] && !list_full) begin
                        state_next = (cnt_reg == '0) ? erq_pkg::ST_PLACE
                                                     : erq_pkg::ST_SCAN_RD;
                    end else begin
                        state_next = erq_pkg::ST_HEAD_RD;
                    end
                end
            end
            erq_pkg::ST_SCAN_RD: begin
                state_next = erq_pkg::ST_SCAN_CHK;
            end
            erq_pkg::ST_SCAN_CHK: begin
                // strictly later deadline moves back; equal ones stay ahead
                if (task_reg.deadline < ram_rdata.deadline) begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    pos_next   = pos_reg - AW'(1);
                    state_next = (pos_reg == AW'(1)) ? erq_pkg::ST_PLACE
                                                     : erq_pkg::ST_SCAN_RD;
                end else begin
                    state_next = erq_pkg::ST_PLACE;
                end
            end
            erq_pkg::ST_PLACE: begin
                ram_we     = 1'b1;
                cnt_next   = cnt_reg + CW'(1);
                state_next = erq_pkg::ST_HEAD_RD;
            end
            erq_pkg::ST_HEAD_RD: begin
                ram_raddr  = '0;
                state_next = erq_pkg::ST_HEAD_CHK;
            end
            erq_pkg::ST_HEAD_CHK: begin
                // release an unreleased head
                if (cnt_reg != '0 && !ram_rdata.released) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = head_upd;
                    rel_next  = 1'b1;
                    head_next = head_upd;
                end
                state_next = erq_pkg::ST_DONE;
            end
            erq_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b000, erq_pkg::OCC_W'(cnt_reg), head_reg.stamp,
                                    head_reg.deadline, head_reg.exec, head_reg.ident};
                    m_user_next  = {drop_reg, head_reg.kind, rel_reg};
                    state_next   = erq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = erq_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= erq_pkg::ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        task_reg   <= task_next;
        now_reg    <= now_next;
        drop_reg   <= drop_next;
        rel_reg    <= rel_next;
        head_reg   <= head_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `include "assert_macros.svh"

    `ASSERT_SAME(a_cnt_bound, 1'b1, cnt_reg <= CW'(QUEUE_DEPTH))
    `ASSERT_SAME(a_drop_full, m_valid_reg && m_user_reg[2], m_data_reg[92:88] == OCC_FULL)
    `ASSERT_SAME(a_rel_nonempty, m_valid_reg && m_user_reg[0], m_data_reg[92:88] != '0)
    `ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_reg != erq_pkg::ST_IDLE)

endmodule
`default_nettype wire

### dv/edf_ready_queue_unit_tb.sv
module edf_ready_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH = erq_pkg::QUEUE_DEPTH_DEF;
    localparam int RANDOM_PASSES = 1000;
    // sender runs without gaps over this stretch of passes
    localparam int CALM_FROM = 400;
    localparam int CALM_TO = 600;
    // sender waits for every release word after this many passes
    localparam int DRAIN_AT = 800;
    // receiver holds off once, after this many result words
    localparam int HOLD_AT = 150;
    localparam int HOLD_CYCLES = 250;

    // one scheduler pass as offered on the input side
    typedef struct packed {
        logic        ins;
        logic [7:0]  ident;
        logic        kind;
        logic [15:0] exec;
        logic [31:0] deadline;
        logic [31:0] now;
    } pass_t;

    // one result word, unpacked
    typedef struct packed {
        logic        rel;
        logic [7:0]  ident;
        logic        kind;
        logic [15:0] exec;
        logic [31:0] deadline;
        logic [31:0] stamp;
        logic        dropped;
        logic [4:0]  occ;
    } release_t;

    // directed row: the pass and, where typed in, its known result
    typedef struct packed {
        pass_t    p;
        logic     typed;
        release_t r;
    } row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [erq_pkg::S_DATA_W-1:0]  s_tdata = '0;
    logic [erq_pkg::S_USER_W-1:0]  s_tuser = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [erq_pkg::M_DATA_W-1:0]  m_tdata;
    logic [erq_pkg::M_USER_W-1:0]  m_tuser;

    // scoreboard of the ready list
    erq_pkg::entry_t held [QDEPTH];
    int         held_count;
    release_t   release_due [$];
    row_t       plan_rows [$];
    int         mismatches;
    int         releases_seen;
    int         passes_sent;

    edf_ready_queue_unit #(
        .QUEUE_DEPTH(QDEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 aclk = ~aclk;

    // sorted insert, then release of an unreleased head
    task automatic run_edf_pass(input pass_t p, output release_t r);
        int pos;
        r = '0;
        if (p.ins) begin
            if (held_count >= QDEPTH) begin
                r.dropped = 1'b1;
            end else begin
                pos = 0;
                // ties go behind the held equal deadlines
                while (pos < held_count && !(p.deadline < held[pos].deadline))
                    pos++;
                for (int k = held_count; k > pos; k--)
                    held[k] = held[k-1];
                held[pos].deadline = p.deadline;
                held[pos].ident = p.ident;
                held[pos].kind = p.kind;
                held[pos].exec = p.exec;
                held[pos].stamp = '0;
                held[pos].released = 1'b0;
                held_count++;
            end
        end
        if (held_count > 0 && !held[0].released) begin
            held[0].stamp = p.now;
            held[0].released = 1'b1;
            r.rel = 1'b1;
            r.ident = held[0].ident;
            r.kind = held[0].kind;
            r.exec = held[0].exec;
            r.deadline = held[0].deadline;
            r.stamp = held[0].stamp;
        end
        r.occ = 5'(held_count);
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            note_mismatch($sformatf("word %0d %s got %h want %h",
                                    releases_seen, name, got, want));
    endtask

    // compare one accepted result word with the oldest pending release
    task automatic check_release();
        release_t got;
        release_t want;
        got.ident = m_tdata[7:0];
        got.exec = m_tdata[23:8];
        got.deadline = m_tdata[55:24];
        got.stamp = m_tdata[87:56];
        got.occ = m_tdata[92:88];
        got.rel = m_tuser[0];
        got.kind = m_tuser[1];
        got.dropped = m_tuser[2];
        if (release_due.size() == 0) begin
            note_mismatch($sformatf("word %0d with nothing pending", releases_seen));
        end else begin
            want = release_due.pop_front();
            compare_field("release_valid", 32'(got.rel), 32'(want.rel));
            compare_field("released_ident", 32'(got.ident), 32'(want.ident));
            compare_field("released_kind", 32'(got.kind), 32'(want.kind));
            compare_field("released_exec", 32'(got.exec), 32'(want.exec));
            compare_field("released_deadline", got.deadline, want.deadline);
            compare_field("release_stamp", got.stamp, want.stamp);
            compare_field("insert_dropped", 32'(got.dropped), 32'(want.dropped));
            compare_field("occupancy", 32'(got.occ), 32'(want.occ));
        end
        releases_seen++;
    endtask

    // offer one word, log its release on accept, then maybe go idle
    task automatic feed_pass(input pass_t p, input logic typed, input release_t known);
        release_t r;
        s_tvalid <= 1'b1;
        s_tdata <= {p.now, p.deadline, p.exec, p.ident};
        s_tuser <= {p.kind, p.ins};
        do @(posedge aclk); while (!s_tready);
        run_edf_pass(p, r);
        release_due.push_back(typed ? known : r);
        passes_sent++;
        if (passes_sent == DRAIN_AT) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (release_due.size() != 0);
        end else if (!(passes_sent >= CALM_FROM && passes_sent < CALM_TO)
                     && $urandom_range(0, 99) < 26) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 26);
        end
    endtask

    task automatic add_row(input pass_t p, input logic typed, input release_t r);
        row_t row;
        row.p = p;
        row.typed = typed;
        row.r = r;
        plan_rows.push_back(row);
    endtask

    // result side: random stalls, one long hold-off, a stall-free stretch
    initial begin : result_sink
        int hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                check_release();
            if (!hold_done && releases_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (releases_seen >= CALM_FROM + 20 && releases_seen < CALM_TO + 20) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 26);
            end
        end
    end

    // stimulus and end of run
    initial begin : pass_source
        pass_t p;
        mismatches = 0;
        releases_seen = 0;
        passes_sent = 0;
        held_count = 0;
        for (int i = 0; i < QDEPTH; i++)
            held[i] = '0;

        // empty list, nothing to release
        add_row('{1'b0, 8'h00, 1'b0, 16'h0000, 32'h0000_0000, 32'd100}, 1'b1,
                '{1'b0, 8'h00, 1'b0, 16'h0000, 32'h0, 32'h0, 1'b0, 5'd0});
        // all-ones task released at once
        add_row('{1'b1, 8'hFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
                '{1'b1, 8'hFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 5'd1});
        // all-zero task lands ahead of the released head
        add_row('{1'b1, 8'h00, 1'b0, 16'h0000, 32'h0000_0000, 32'h0000_0000}, 1'b1,
                '{1'b1, 8'h00, 1'b0, 16'h0000, 32'h0, 32'h0, 1'b0, 5'd2});
        // equal deadline queues behind the head, no release
        add_row('{1'b1, 8'h5A, 1'b1, 16'h1234, 32'h0000_0000, 32'd300}, 1'b1,
                '{1'b0, 8'h00, 1'b0, 16'h0000, 32'h0, 32'h0, 1'b0, 5'd3});
        add_row('{1'b0, 8'hA5, 1'b1, 16'hFFFF, 32'h0000_0000, 32'd400}, 1'b1,
                '{1'b0, 8'h00, 1'b0, 16'h0000, 32'h0, 32'h0, 1'b0, 5'd3});
        // fill the list, with ties and deadline extremes
        add_row('{1'b1, 8'h11, 1'b0, 16'd100, 32'd1000, 32'd500}, 1'b0, '0);
        add_row('{1'b1, 8'h22, 1'b1, 16'd200, 32'd500, 32'd600}, 1'b0, '0);
        add_row('{1'b1, 8'h33, 1'b0, 16'd300, 32'd1000, 32'd700}, 1'b0, '0);
        add_row('{1'b1, 8'h44, 1'b1, 16'h8000, 32'h8000_0000, 32'd800}, 1'b0, '0);
        add_row('{1'b1, 8'h55, 1'b0, 16'h7FFF, 32'h7FFF_FFFF, 32'd900}, 1'b0, '0);
        add_row('{1'b1, 8'h66, 1'b1, 16'h0001, 32'd1, 32'd1000}, 1'b0, '0);
        add_row('{1'b0, 8'h00, 1'b0, 16'h0000, 32'h0, 32'h1234_5678}, 1'b0, '0);
        add_row('{1'b1, 8'h77, 1'b0, 16'h0002, 32'd2, 32'd1100}, 1'b0, '0);
        add_row('{1'b1, 8'h88, 1'b1, 16'h00FF, 32'd500, 32'd1200}, 1'b0, '0);
        add_row('{1'b1, 8'h99, 1'b0, 16'hFF00, 32'hFFFF_FFFF, 32'd1300}, 1'b0, '0);
        add_row('{1'b1, 8'hAA, 1'b1, 16'hAAAA, 32'd3000, 32'd1400}, 1'b0, '0);
        add_row('{1'b1, 8'hBB, 1'b0, 16'h5555, 32'd20, 32'd1500}, 1'b0, '0);
        add_row('{1'b1, 8'hCC, 1'b1, 16'h0007, 32'h5555_5555, 32'd1600}, 1'b0, '0);
        add_row('{1'b1, 8'hDD, 1'b0, 16'h0009, 32'hAAAA_AAAA, 32'd1700}, 1'b0, '0);
        // full list: insert refused, release step finds the head released
        add_row('{1'b1, 8'hEE, 1'b1, 16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b1,
                '{1'b0, 8'h00, 1'b0, 16'h0000, 32'h0, 32'h0, 1'b1, 5'd16});
        add_row('{1'b0, 8'hFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b1,
                '{1'b0, 8'h00, 1'b0, 16'h0000, 32'h0, 32'h0, 1'b0, 5'd16});
        add_row('{1'b1, 8'h01, 1'b0, 16'h0001, 32'hFFFF_FFFF, 32'd1800}, 1'b1,
                '{1'b0, 8'h00, 1'b0, 16'h0000, 32'h0, 32'h0, 1'b1, 5'd16});

        // reset, then release on a clock edge
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan_rows[i])
            feed_pass(plan_rows[i].p, plan_rows[i].typed, plan_rows[i].r);

        // random passes against the filled list
        for (int n = 0; n < RANDOM_PASSES; n++) begin
            p.ins = ($urandom_range(0, 99) < 60);
            p.ident = 8'($urandom_range(0, 255));
            p.kind = 1'($urandom_range(0, 1));
            p.exec = 16'($urandom_range(0, 65535));
            p.deadline = $urandom;
            p.now = $urandom;
            feed_pass(p, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (release_due.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
